// ----- sv/srplc_pkg.sv -----
// Shared constants, command codes and altitude limit tables for the slew controller.
package srplc_pkg;

	localparam int ALT_TABLE_ENTRIES_DEF = 11;
	localparam int COUNTER_BITS_DEF      = 24;

	localparam int MIN_RATE_RESET = 1000;
	localparam int DEC_MIN_STEPS  = 365634;
	localparam int DEC_INC_STEPS  = 19068;
	localparam int DI_W           = 15;   // bits of a remainder below DEC_INC_STEPS
	localparam int GRAD_W         = 17;
	localparam int QUOT_BITS      = 17;

	// 1/5 as a reciprocal: floor(x * RECIP5 / 2^RECIP5_SH) == x / 5 for x < 2^18
	localparam int RECIP5    = 52429;
	localparam int RECIP5_SH = 18;

	// division by the declination step as a reciprocal multiply, exact below 2^31
	localparam int     RECIP_DEC_SH = 46;
	localparam longint RECIP_DEC    =
		((longint'(1) << RECIP_DEC_SH) + DEC_INC_STEPS - 1) / DEC_INC_STEPS;

	localparam int BIT_N = 0;
	localparam int BIT_S = 1;
	localparam int BIT_E = 2;
	localparam int BIT_W = 3;

	typedef enum logic [2:0] {
		CMD_START  = 3'd0,
		CMD_CHANGE = 3'd1,
		CMD_END    = 3'd2,
		CMD_STOP   = 3'd3,
		CMD_RAMP   = 3'd4,
		CMD_POS    = 3'd5,
		CMD_LIMITS = 3'd6
	} cmd_t;

	typedef int tbl_t [16];

	localparam tbl_t WEST_TBL = '{
		-3520, 19677, 43880, 69600, 97474, 128323, 163334, 204335,
		254504, 320569, 424189, 424189, 424189, 424189, 424189, 424189};
	localparam tbl_t EAST_TBL = '{
		1168912, 1145715, 1121512, 1095792, 1067917, 1037069, 1002058, 961057,
		910888, 844823, 741203, 741203, 741203, 741203, 741203, 741203};

	function automatic tbl_t calc_grad();
		tbl_t g;
		for (int i = 0; i < 15; i++) g[i] = WEST_TBL[i+1] - WEST_TBL[i];
		g[15] = 0;
		return g;
	endfunction

	// (grad * DEC_MIN_STEPS) mod DEC_INC_STEPS, folded out of the interpolation
	function automatic tbl_t calc_gamod();
		tbl_t   g;
		tbl_t   m;
		longint p;
		g = calc_grad();
		for (int i = 0; i < 16; i++) begin
			p    = longint'(g[i]) * DEC_MIN_STEPS;
			m[i] = int'(p % DEC_INC_STEPS);
		end
		return m;
	endfunction

	localparam tbl_t GRAD_TBL  = calc_grad();
	localparam tbl_t GAMOD_TBL = calc_gamod();

	typedef struct packed {
		logic load;
		logic exec;
		logic srch;
		logic mul;
		logic div;
		logic fin;
		logic publish;
	} dp_cmd_t;

	typedef struct packed {
		logic soft_req;
		logic srch_done;
	} dp_sts_t;

endpackage

// ----- sv/srplc_ifs.sv -----
// Command and result channel interfaces.
interface srplc_in_if #(parameter int CNT_W = 24);
	logic             valid;
	logic             ready;
	logic [2:0]       cmd;
	logic [3:0]       direction;
	logic [15:0]      rate;
	logic [CNT_W-1:0] counter_readback;
	logic [3:0]       limit_switches;
	modport source (output valid, cmd, direction, rate, counter_readback, limit_switches,
		input ready);
	modport sink (input valid, cmd, direction, rate, counter_readback, limit_switches,
		output ready);
endinterface

interface srplc_out_if #(parameter int CNT_W = 24);
	logic               valid;
	logic               ready;
	logic               status;
	logic               rate_write;
	logic [15:0]        rate_value;
	logic               dir_write;
	logic [3:0]         dir_value;
	logic               track_off;
	logic               counter_load;
	logic [CNT_W-1:0]   counter_value;
	logic signed [31:0] position_ha;
	logic signed [31:0] position_dec;
	logic [3:0]         limit_flags;
	modport source (output valid, status, rate_write, rate_value, dir_write, dir_value,
		track_off, counter_load, counter_value, position_ha, position_dec, limit_flags,
		input ready);
	modport sink (input valid, status, rate_write, rate_value, dir_write, dir_value,
		track_off, counter_load, counter_value, position_ha, position_dec, limit_flags,
		output ready);
endinterface

// ----- sv/slew_ramp_position_limit_controller.sv -----
// Top level: two-axis slew controller with rate ramp, position tracking and limits.
// One command beat in, one result beat out. Most commands go from execute straight to
// publish; read limits with a declination inside the soft limit table adds the interval
// search, a multiply, a reciprocal-multiply divide by the declination step and a compare
// before publishing. The next command is taken the cycle after a result is published;
// publishing waits while an earlier result beat is still held untaken.
module slew_ramp_position_limit_controller import srplc_pkg::*; #(
	parameter int ALT_TABLE_ENTRIES = ALT_TABLE_ENTRIES_DEF,
	parameter int COUNTER_BITS      = COUNTER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	srplc_in_if.sink    in_ch,
	srplc_out_if.source out_ch
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	srplc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.dp_cmd    (dp_cmd),
		.dp_sts    (dp_sts)
	);

	srplc_dp #(
		.ALT_TABLE_ENTRIES (ALT_TABLE_ENTRIES),
		.COUNTER_BITS      (COUNTER_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.dp_cmd           (dp_cmd),
		.dp_sts           (dp_sts),
		.cmd              (in_ch.cmd),
		.direction        (in_ch.direction),
		.rate             (in_ch.rate),
		.counter_readback (in_ch.counter_readback),
		.limit_switches   (in_ch.limit_switches),
		.status           (out_ch.status),
		.rate_write       (out_ch.rate_write),
		.rate_value       (out_ch.rate_value),
		.dir_write        (out_ch.dir_write),
		.dir_value        (out_ch.dir_value),
		.track_off        (out_ch.track_off),
		.counter_load     (out_ch.counter_load),
		.counter_value    (out_ch.counter_value),
		.position_ha      (out_ch.position_ha),
		.position_dec     (out_ch.position_dec),
		.limit_flags      (out_ch.limit_flags)
	);

endmodule

// ----- sv/srplc_ctrl.sv -----
// Sequencer: steps one command through execute, limit search, multiply, divide, compare and publish.
module srplc_ctrl import srplc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t dp_cmd,
	input  dp_sts_t dp_sts
);

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_SRCH, S_MUL, S_DIV, S_FIN, S_PUB
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   pub_ok;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign pub_ok    = (state_q == S_PUB) && (!out_valid_q || out_ready);

	always_comb begin
		dp_cmd         = '0;
		dp_cmd.load    = in_valid && (state_q == S_IDLE);
		dp_cmd.exec    = (state_q == S_EXEC);
		dp_cmd.srch    = (state_q == S_SRCH);
		dp_cmd.mul     = (state_q == S_MUL);
		dp_cmd.div     = (state_q == S_DIV);
		dp_cmd.fin     = (state_q == S_FIN);
		dp_cmd.publish = pub_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (pub_ok) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: state_q <= dp_sts.soft_req ? S_SRCH : S_PUB;
				S_SRCH: if (dp_sts.srch_done) state_q <= S_MUL;
				S_MUL:  state_q <= S_DIV;
				S_DIV:  state_q <= S_FIN;
				S_FIN:  state_q <= S_PUB;
				S_PUB:  if (pub_ok) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/srplc_dp.sv -----
// Datapath: rate ramp, position tracking, limit switches and soft limit interpolation.
module srplc_dp import srplc_pkg::*; #(
	parameter int ALT_TABLE_ENTRIES = ALT_TABLE_ENTRIES_DEF,
	parameter int COUNTER_BITS      = COUNTER_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [15:0]             cfg_wdata,
	input  dp_cmd_t                 dp_cmd,
	output dp_sts_t                 dp_sts,
	input  logic [2:0]              cmd,
	input  logic [3:0]              direction,
	input  logic [15:0]             rate,
	input  logic [COUNTER_BITS-1:0] counter_readback,
	input  logic [3:0]              limit_switches,
	output logic                    status,
	output logic                    rate_write,
	output logic [15:0]             rate_value,
	output logic                    dir_write,
	output logic [3:0]              dir_value,
	output logic                    track_off,
	output logic                    counter_load,
	output logic [COUNTER_BITS-1:0] counter_value,
	output logic signed [31:0]      position_ha,
	output logic signed [31:0]      position_dec,
	output logic [3:0]              limit_flags
);

	localparam int FULL_SPAN = (ALT_TABLE_ENTRIES - 1) * DEC_INC_STEPS;
	localparam int REM_W     = $clog2(FULL_SPAN);

	// architectural state
	logic [15:0]             min_rate_q;
	logic signed [31:0]      pos_ha_q, pos_dec_q;
	logic [COUNTER_BITS-1:0] last_q;
	logic [3:0]              move_q;
	logic [15:0]             tgt_q, cur_q;
	logic                    ending_q;

	// item capture
	cmd_t                    cmd_q;
	logic [3:0]              dir_q, sw_q;
	logic [15:0]             rate_q;
	logic [COUNTER_BITS-1:0] rb_q;

	// result under construction
	logic                    st_q, rw_q, dw_q, cl_q;
	logic [15:0]             rv_q;
	logic [3:0]              dv_q, lf_q;
	logic [COUNTER_BITS-1:0] cv_q;

	// soft limit working registers
	logic [REM_W-1:0]        rem_q;
	logic [3:0]              idx_q;
	logic [31:0]             num_q;
	logic [QUOT_BITS-1:0]    quot_q;

	// next-state terms for execute
	logic                    trk;
	logic [31:0]             delta;
	logic signed [31:0]      ha_trk, dec_trk, ha_z, dec_z;
	logic                    conflict;
	logic signed [32:0]      ddiff;
	logic                    dec_ge, dec_full;
	logic [15:0]             start_rate, req_clamp;
	logic [33:0]             down_prod;
	logic [15:0]             down_q5, up_cl, ramp_nr;
	logic [18:0]             up_x;
	logic [31:0]             prod;
	logic [63:0]             qprod;
	logic signed [33:0]      ha_x, lim_w, lim_e;

	assign trk   = (cur_q != '0) && (move_q != '0);
	assign delta = 32'(rb_q) - 32'(last_q);

	always_comb begin
		ha_trk  = pos_ha_q;
		dec_trk = pos_dec_q;
		if (trk) begin
			if (move_q[BIT_W]) ha_trk = pos_ha_q + delta;
			else if (move_q[BIT_E]) ha_trk = pos_ha_q - delta;
			if (move_q[BIT_N]) dec_trk = pos_dec_q + delta;
			else if (move_q[BIT_S]) dec_trk = pos_dec_q - delta;
		end
	end

	assign conflict = (sw_q[BIT_W] && sw_q[BIT_E]) || (sw_q[BIT_N] && sw_q[BIT_S]);
	assign ha_z     = sw_q[BIT_W] ? '0 : pos_ha_q;
	assign dec_z    = sw_q[BIT_S] ? '0 : pos_dec_q;
	assign ddiff    = 33'(dec_z) - 33'(DEC_MIN_STEPS);
	assign dec_ge   = !ddiff[32];
	assign dec_full = dec_ge && (ddiff >= 33'(FULL_SPAN));

	assign start_rate = (rate_q >= min_rate_q) ? rate_q : min_rate_q;
	assign req_clamp  = (rate_q < min_rate_q) ? min_rate_q : rate_q;

	// ramp down: cur*4/5 by reciprocal; ramp up: cur*5/4
	assign down_prod = {16'b0, cur_q, 2'b00} * 34'(RECIP5);
	assign down_q5   = 16'(down_prod >> RECIP5_SH);
	assign up_x      = ({3'b0, cur_q} << 2) + {3'b0, cur_q};
	assign up_cl     = ((up_x >> 2) > 19'(tgt_q)) ? tgt_q : 16'(up_x >> 2);
	assign ramp_nr   = (tgt_q < cur_q) ? ((down_q5 < tgt_q) ? tgt_q : down_q5) : up_cl;

	assign prod    = 32'(GAMOD_TBL[idx_q]) +
		(32'($unsigned(GRAD_W'(GRAD_TBL[idx_q]))) * 32'(rem_q[DI_W-1:0]));
	assign qprod   = 64'(num_q) * 64'(RECIP_DEC);

	assign ha_x  = 34'(pos_ha_q);
	assign lim_w = 34'(WEST_TBL[idx_q]) + 34'(quot_q);
	assign lim_e = 34'(EAST_TBL[idx_q]) - 34'(quot_q);

	assign dp_sts.soft_req  = (cmd_q == CMD_LIMITS) && !conflict && dec_ge && !dec_full;
	assign dp_sts.srch_done = (rem_q < REM_W'(DEC_INC_STEPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rate_q <= 16'(MIN_RATE_RESET);
			pos_ha_q   <= '0;
			pos_dec_q  <= '0;
			last_q     <= '0;
			move_q     <= '0;
			tgt_q      <= '0;
			cur_q      <= '0;
			ending_q   <= 1'b0;
		end else begin
			if (cfg_we) min_rate_q <= cfg_wdata;
			if (dp_cmd.exec) begin
				case (cmd_q)
					CMD_START: if (cur_q == '0) begin
						cur_q    <= start_rate;
						tgt_q    <= rate_q;
						move_q   <= dir_q;
						ending_q <= 1'b0;
						last_q   <= '1;
					end
					CMD_CHANGE: if (cur_q != '0) begin
						tgt_q <= rate_q;
						if (cur_q >= min_rate_q) cur_q <= req_clamp;
					end
					CMD_END: begin
						if (cur_q != '0 && cur_q >= min_rate_q) begin
							pos_ha_q  <= ha_trk;
							pos_dec_q <= dec_trk;
							last_q    <= '0;
							cur_q     <= '0;
							ending_q  <= 1'b0;
						end else if (cur_q != '0 && !ending_q) begin
							ending_q <= 1'b1;
							tgt_q    <= min_rate_q;
						end
					end
					CMD_STOP: begin
						pos_ha_q  <= ha_trk;
						pos_dec_q <= dec_trk;
						last_q    <= '0;
						cur_q     <= '0;
						ending_q  <= 1'b0;
					end
					CMD_RAMP: if (tgt_q != cur_q) cur_q <= ramp_nr;
					CMD_POS: if (trk) begin
						pos_ha_q  <= ha_trk;
						pos_dec_q <= dec_trk;
						last_q    <= rb_q;
					end
					CMD_LIMITS: if (!conflict) begin
						pos_ha_q  <= ha_z;
						pos_dec_q <= dec_z;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q  <= cmd_t'(cmd);
			dir_q  <= direction;
			rate_q <= rate;
			rb_q   <= counter_readback;
			sw_q   <= limit_switches;
		end
		if (dp_cmd.exec) begin
			st_q <= 1'b0;
			rw_q <= 1'b0;
			rv_q <= '0;
			dw_q <= 1'b0;
			dv_q <= '0;
			cl_q <= 1'b0;
			cv_q <= '0;
			lf_q <= '0;
			rem_q <= ddiff[REM_W-1:0];
			idx_q <= '0;
			case (cmd_q)
				CMD_START: if (cur_q == '0) begin
					st_q <= 1'b1;
					rw_q <= 1'b1;
					rv_q <= start_rate;
					dw_q <= 1'b1;
					dv_q <= dir_q;
					cl_q <= 1'b1;
					cv_q <= '1;
				end
				CMD_CHANGE: if (cur_q != '0 && cur_q >= min_rate_q) begin
					rw_q <= 1'b1;
					rv_q <= req_clamp;
				end
				CMD_END: if (cur_q == '0) begin
					st_q <= 1'b1;
				end else if (cur_q >= min_rate_q) begin
					st_q <= 1'b1;
					dw_q <= 1'b1;
					cl_q <= 1'b1;
				end
				CMD_STOP: begin
					dw_q <= 1'b1;
					cl_q <= 1'b1;
				end
				CMD_RAMP: if (tgt_q != cur_q) begin
					st_q <= 1'b1;
					rw_q <= 1'b1;
					rv_q <= ramp_nr;
				end
				CMD_LIMITS: begin
					if (conflict) lf_q <= 4'hF;
					else if (dec_full)
						lf_q <= sw_q | 4'((1 << BIT_N) | (1 << BIT_W) | (1 << BIT_E));
					else lf_q <= sw_q;
				end
				default: ;
			endcase
		end
		if (dp_cmd.srch && !dp_sts.srch_done) begin
			rem_q <= rem_q - REM_W'(DEC_INC_STEPS);
			idx_q <= idx_q + 4'd1;
		end
		if (dp_cmd.mul) num_q <= prod;
		// divide by the declination step as a reciprocal multiply
		if (dp_cmd.div) quot_q <= qprod[RECIP_DEC_SH +: QUOT_BITS];
		if (dp_cmd.fin)
			lf_q <= lf_q | ((ha_x < lim_w) ? 4'((1 << BIT_N) | (1 << BIT_W)) : 4'd0) |
				((ha_x > lim_e) ? 4'((1 << BIT_N) | (1 << BIT_E)) : 4'd0);
		if (dp_cmd.publish) begin
			status        <= st_q;
			rate_write    <= rw_q;
			rate_value    <= rv_q;
			dir_write     <= dw_q;
			dir_value     <= dv_q;
			track_off     <= dw_q;
			counter_load  <= cl_q;
			counter_value <= cv_q;
			position_ha   <= pos_ha_q;
			position_dec  <= pos_dec_q;
			limit_flags   <= lf_q;
		end
	end

endmodule

// ----- sv/srplc_chk.sv -----
// Port-level checks on the result channel, bound to the top level.
module srplc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        status,
	input logic        rate_write,
	input logic [15:0] rate_value,
	input logic        dir_write,
	input logic        track_off,
	input logic        counter_load,
	input logic [3:0]  limit_flags
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped before taken");

	a_load_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && counter_load |-> dir_write && track_off)
		else $error("counter load without direction write");

	a_rate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rate_write |-> rate_value == 16'd0)
		else $error("rate value without rate write");

	a_limits_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && limit_flags != 4'd0 |-> !rate_write && !dir_write && !status)
		else $error("limit flags mixed with drive writes");

endmodule

bind slew_ramp_position_limit_controller srplc_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.status       (out_ch.status),
	.rate_write   (out_ch.rate_write),
	.rate_value   (out_ch.rate_value),
	.dir_write    (out_ch.dir_write),
	.track_off    (out_ch.track_off),
	.counter_load (out_ch.counter_load),
	.limit_flags  (out_ch.limit_flags)
);
